[hdl/header_payload_deframer_assert.svh]
// Assertion macros of the deframer RTL, used by its top level.
`ifndef HEADER_PAYLOAD_DEFRAMER_ASSERT_SVH
`define HEADER_PAYLOAD_DEFRAMER_ASSERT_SVH

// Plain property check, disabled while reset is asserted.
`define HPD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("deframer assertion failed");

// Same-cycle implication check, disabled while reset is asserted.
`define HPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer implication failed");

// Next-cycle implication check, disabled while reset is asserted.
`define HPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer sequence failed");

`endif

[hdl/hpd_pkg.sv]
// Types and constants of the header/payload deframer.
`timescale 1ns / 1ps

package hpd_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int HDR_CNT_W = 4;
    localparam logic [15:0] CHECK_WORD = 16'hADDE;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_ABORT = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [15:0] command_code;
        logic [31:0] msg_id;
        logic [31:0] total_size;
        logic [31:0] byte_offset;
        logic [7:0]  data_byte;
        logic        last_of_message;
    } t_result;

    typedef struct packed {
        logic                 in_payload;
        logic [HDR_CNT_W-1:0] header_count;
    } t_status;

endpackage

[hdl/header_payload_deframer.sv]
// Top level of the header/payload deframer.
//
// The slave channel takes one item per byte of the stream: tuser set means an
// abort that drops back to header hunting, otherwise tdata carries the byte.
// Twelve header bytes (command, size, check word 0xADDE, id, little-endian)
// give one accepted or rejected header item on the master channel. After an
// accepted header each payload byte gives one data item carrying the header
// fields, the running offset and tlast on the final byte. A header with size
// zero completes at once with tlast set on the accepted item.
// An item passes an input register and then the result register before its
// result is shown. One item is taken in every cycle while tready is high; the
// header compare is combinational and the payload counter moves with each item.
// When the receiver stalls, the result register holds its item and the input
// register fills; tready drops only when both are occupied.
// Reset clears both registers and returns the block to header hunting with
// all header fields and the payload count at zero.
`timescale 1ns / 1ps

module header_payload_deframer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // rx_byte
    input  logic [0:0]    s_axis_tuser,   // req_type
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [119:0]  m_axis_tdata,   // command_code, msg_id, total_size,
                                          // byte_offset, data_byte
    output logic [1:0]    m_axis_tuser,   // kind
    output logic          m_axis_tlast    // last_of_message
);
    import hpd_pkg::*;

    logic       r_in_valid;
    logic       r_in_req;
    logic [7:0] r_in_byte;

    logic       w_out_free;
    logic       w_advance;
    t_result    w_core_res;
    t_result    w_out_res;
    t_status    w_status;

    assign w_advance = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req <= s_axis_tuser[0];
            r_in_byte <= s_axis_tdata;
        end
    end

    hpd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_advance),
        .i_req_type (r_in_req),
        .i_rx_byte  (r_in_byte),
        .o_result   (w_core_res),
        .o_status   (w_status)
    );

    hpd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_core_res.valid),
        .i_result (w_core_res),
        .i_ready  (m_axis_tready),
        .o_free   (w_out_free),
        .o_result (w_out_res)
    );

    assign m_axis_tvalid = w_out_res.valid;
    assign m_axis_tdata = {w_out_res.data_byte, w_out_res.byte_offset,
                           w_out_res.total_size, w_out_res.msg_id,
                           w_out_res.command_code};
    assign m_axis_tuser = w_out_res.kind;
    assign m_axis_tlast = w_out_res.last_of_message;

`include "header_payload_deframer_assert.svh"

    `HPD_ASSERT_IMP(a_payload_no_count, w_status.in_payload, w_status.header_count == '0)
    `HPD_ASSERT_IMP(a_offset_in_range, m_axis_tvalid && m_axis_tuser == KIND_DATA,
        m_axis_tdata[111:80] != 32'd0 && m_axis_tdata[111:80] <= m_axis_tdata[79:48])
    `HPD_ASSERT_IMP(a_reject_not_last, m_axis_tvalid && m_axis_tuser == KIND_REJECT,
        !m_axis_tlast)
    `HPD_ASSERT_NEXT(a_input_held, r_in_valid && !w_out_free, r_in_valid)

endmodule

[hdl/hpd_core.sv]
// Header collection, header check and payload tracking of the deframer.
`timescale 1ns / 1ps

module hpd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_req_type,
    input  logic [7:0]       i_rx_byte,
    output hpd_pkg::t_result o_result,
    output hpd_pkg::t_status o_status
);
    import hpd_pkg::*;

    logic                 r_in_payload;
    logic [HDR_CNT_W-1:0] r_count;
    logic [7:0]           r_hdr [HEADER_BYTES];
    logic [15:0]          r_command;
    logic [31:0]          r_size;
    logic [31:0]          r_id;
    logic [31:0]          r_recv;

    logic                 n_in_payload;
    logic [HDR_CNT_W-1:0] n_count;
    logic [15:0]          n_command;
    logic [31:0]          n_size;
    logic [31:0]          n_id;
    logic [31:0]          n_recv;

    logic [HDR_CNT_W-1:0] w_cnt;
    logic                 w_hdr_we;
    logic [15:0]          w_check;
    logic [31:0]          w_recv_inc;
    t_result              w_res;

    assign w_cnt = (r_count >= HDR_CNT_W'(HEADER_BYTES)) ? '0 : r_count;
    assign w_check = {r_hdr[7], r_hdr[6]};
    assign w_recv_inc = r_recv + 32'd1;

    always_comb begin
        n_in_payload = r_in_payload;
        n_count = r_count;
        n_command = r_command;
        n_size = r_size;
        n_id = r_id;
        n_recv = r_recv;
        w_hdr_we = 1'b0;
        w_res = '0;
        if (i_req_type == REQ_ABORT) begin
            n_in_payload = 1'b0;
            n_count = '0;
        end else if (r_in_payload) begin
            n_recv = w_recv_inc;
            w_res.valid = 1'b1;
            w_res.kind = KIND_DATA;
            w_res.byte_offset = w_recv_inc;
            w_res.data_byte = i_rx_byte;
            if (w_recv_inc == r_size) begin
                n_in_payload = 1'b0;
                w_res.last_of_message = 1'b1;
            end
        end else begin
            w_hdr_we = 1'b1;
            if (w_cnt != HDR_CNT_W'(HEADER_BYTES - 1)) begin
                n_count = w_cnt + HDR_CNT_W'(1);
            end else begin
                // The incoming byte is the last header byte, the top of the id.
                n_count = '0;
                n_command = {r_hdr[1], r_hdr[0]};
                n_size = {r_hdr[5], r_hdr[4], r_hdr[3], r_hdr[2]};
                n_id = {i_rx_byte, r_hdr[10], r_hdr[9], r_hdr[8]};
                w_res.valid = 1'b1;
                if (w_check != CHECK_WORD) begin
                    w_res.kind = KIND_REJECT;
                end else begin
                    w_res.kind = KIND_ACCEPT;
                    n_recv = '0;
                    if (n_size == 32'd0) begin
                        w_res.last_of_message = 1'b1;
                    end else begin
                        n_in_payload = 1'b1;
                    end
                end
            end
        end
        w_res.command_code = n_command;
        w_res.msg_id = n_id;
        w_res.total_size = n_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_count <= '0;
            r_command <= '0;
            r_size <= '0;
            r_id <= '0;
            r_recv <= '0;
        end else if (i_en) begin
            r_in_payload <= n_in_payload;
            r_count <= n_count;
            r_command <= n_command;
            r_size <= n_size;
            r_id <= n_id;
            r_recv <= n_recv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && w_hdr_we) begin
            r_hdr[w_cnt] <= i_rx_byte;
        end
    end

    assign o_result = w_res;
    assign o_status = '{in_payload: r_in_payload, header_count: r_count};

endmodule

[hdl/hpd_out_reg.sv]
// Result register of the deframer, holding one item until the receiver takes it.
`timescale 1ns / 1ps

module hpd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  hpd_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_free,
    output hpd_pkg::t_result o_result
);
    import hpd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    always_comb begin
        o_result = r_res;
        o_result.valid = r_valid;
    end

endmodule

[tb/tb_header_payload_deframer.sv]
`timescale 1ns / 1ps
// Self-checking stream testbench for the header/payload deframer with its own predictor.
module tb_header_payload_deframer;
    import hpd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int MAX_PRINTED = 50;
    localparam int TAIL_CYCLES = 10;

    typedef struct packed {
        logic       req;
        logic [7:0] rx_byte;
    } stream_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] command_code;
        logic [31:0] msg_id;
        logic [31:0] total_size;
        logic [31:0] byte_offset;
        logic [7:0]  data_byte;
        logic        last_of_message;
    } deframe_result_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;    // rx_byte
    logic [0:0]   s_axis_tuser = '0;    // req_type
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;         // command_code, msg_id, total_size,
                                        // byte_offset, data_byte
    logic [1:0]   m_axis_tuser;         // kind
    logic         m_axis_tlast;         // last_of_message

    header_payload_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    stream_item_t    pending_items[$];
    deframe_result_t expected_results[$];

    logic        in_message = 1'b0;
    int unsigned hdr_fill = 0;
    logic [7:0]  hdr_buf [HEADER_BYTES];
    logic [15:0] msg_command = '0;
    logic [31:0] msg_size = '0;
    logic [31:0] msg_ident = '0;
    logic [31:0] payload_seen = '0;

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned items_taken = 0;
    int unsigned aborts_seen = 0;
    int unsigned headers_accepted = 0;
    int unsigned headers_rejected = 0;
    int unsigned payload_bytes = 0;
    int unsigned queued_total = 0;

    logic        in_taken = 1'b0;
    logic        idling_on = 1'b1;
    int unsigned stalls_requested = 0;
    int unsigned stalls_served = 0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          hold_left = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic predict_deframe(input logic req, input logic [7:0] b);
        deframe_result_t r;
        logic [15:0]     chk;
        r = '0;
        items_taken++;
        if (req == REQ_ABORT) begin
            in_message = 1'b0;
            hdr_fill = 0;
            aborts_seen++;
        end else if (in_message) begin
            payload_seen = payload_seen + 32'd1;
            r.kind = KIND_DATA;
            r.byte_offset = payload_seen;
            r.data_byte = b;
            r.last_of_message = (payload_seen == msg_size);
            if (r.last_of_message) begin
                in_message = 1'b0;
            end
            r.command_code = msg_command;
            r.msg_id = msg_ident;
            r.total_size = msg_size;
            expected_results.push_back(r);
            payload_bytes++;
        end else begin
            hdr_buf[hdr_fill] = b;
            hdr_fill++;
            if (hdr_fill == HEADER_BYTES) begin
                hdr_fill = 0;
                msg_command = {hdr_buf[1], hdr_buf[0]};
                msg_size = {hdr_buf[5], hdr_buf[4], hdr_buf[3], hdr_buf[2]};
                chk = {hdr_buf[7], hdr_buf[6]};
                msg_ident = {hdr_buf[11], hdr_buf[10], hdr_buf[9], hdr_buf[8]};
                if (chk != CHECK_WORD) begin
                    r.kind = KIND_REJECT;
                    headers_rejected++;
                end else begin
                    payload_seen = '0;
                    r.kind = KIND_ACCEPT;
                    r.last_of_message = (msg_size == 32'd0);
                    in_message = (msg_size != 32'd0);
                    headers_accepted++;
                end
                r.command_code = msg_command;
                r.msg_id = msg_ident;
                r.total_size = msg_size;
                expected_results.push_back(r);
            end
        end
    endtask

    always @(posedge i_clk) begin
        deframe_result_t got;
        deframe_result_t want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_deframe(s_axis_tuser[0], s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser;
                got.command_code = m_axis_tdata[15:0];
                got.msg_id = m_axis_tdata[47:16];
                got.total_size = m_axis_tdata[79:48];
                got.byte_offset = m_axis_tdata[111:80];
                got.data_byte = m_axis_tdata[119:112];
                got.last_of_message = m_axis_tlast;
                if (expected_results.size() == 0) begin
                    report_mismatch("result item arrived with none expected");
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    check_field("kind", 32'(got.kind), 32'(want.kind));
                    check_field("command_code", 32'(got.command_code),
                                32'(want.command_code));
                    check_field("msg_id", got.msg_id, want.msg_id);
                    check_field("total_size", got.total_size, want.total_size);
                    check_field("byte_offset", got.byte_offset, want.byte_offset);
                    check_field("data_byte", 32'(got.data_byte), 32'(want.data_byte));
                    check_field("last_of_message", 32'(got.last_of_message),
                                32'(want.last_of_message));
                end
            end
        end
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    always @(negedge i_clk) begin
        stream_item_t item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (tx_gap != 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 11) == 0) begin
                tx_gap = $urandom_range(0, 13);
                s_axis_tvalid <= 1'b0;
            end else begin
                item = pending_items.pop_front();
                s_axis_tuser <= item.req;
                s_axis_tdata <= item.rx_byte;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stalls_served != stalls_requested) begin
            stalls_served++;
            hold_left = LONG_STALL_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 11) == 0) begin
            rx_gap = $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still outstanding.",
                     cycle_count, expected_results.size());
            $display("header_payload_deframer verification failed");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        pending_items.push_back(stream_item_t'{req: REQ_BYTE, rx_byte: b});
        queued_total++;
    endtask

    task automatic queue_abort();
        pending_items.push_back(stream_item_t'{req: REQ_ABORT, rx_byte: 8'($urandom)});
        queued_total++;
    endtask

    task automatic queue_header(input logic [15:0] cmd, input logic [31:0] size,
                                input logic [15:0] chk, input logic [31:0] id,
                                input int n_bytes);
        logic [95:0] hdr;
        hdr = {id, chk, size, cmd};
        for (int i = 0; i < n_bytes; i++) begin
            queue_byte(hdr[8*i +: 8]);
        end
    endtask

    task automatic queue_payload(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            queue_byte(8'($urandom));
        end
    endtask

    task automatic queue_random_message();
        int unsigned pick;
        int unsigned k;
        logic [15:0] cmd;
        logic [15:0] chk;
        logic [31:0] size;
        logic [31:0] id;
        pick = $urandom_range(0, 99);
        cmd = 16'($urandom);
        id = $urandom;
        chk = CHECK_WORD;
        if (pick < 4) begin
            queue_abort();
        end else if (pick < 9) begin
            // Unframed bytes leave the header counter misaligned, so an abort realigns.
            queue_payload($urandom_range(1, 11));
            queue_abort();
        end else begin
            k = $urandom_range(0, 99);
            if (k < 12) begin
                size = 32'd0;
            end else if (k < 82) begin
                size = $urandom_range(1, 8);
            end else if (k < 94) begin
                size = $urandom_range(9, 40);
            end else begin
                size = $urandom;
            end
            k = $urandom_range(0, 99);
            if (k < 8) begin
                chk = CHECK_WORD ^ (16'h1 << $urandom_range(0, 15));
            end else if (k < 12) begin
                chk = 16'($urandom);
            end
            if ($urandom_range(0, 99) < 5) begin
                queue_header(cmd, size, chk, id, $urandom_range(1, HEADER_BYTES - 1));
                queue_abort();
            end else begin
                queue_header(cmd, size, chk, id, HEADER_BYTES);
                if (chk == CHECK_WORD && size != 32'd0) begin
                    if (size > 32'd40 || $urandom_range(0, 99) < 5) begin
                        queue_payload($urandom_range(0, (size > 32'd6) ? 6 : size - 1));
                        queue_abort();
                    end else begin
                        queue_payload(size);
                    end
                end
            end
        end
    endtask

    task automatic queue_random_stream(input int unsigned n_items);
        int unsigned goal;
        goal = queued_total + n_items;
        while (queued_total < goal) begin
            queue_random_message();
        end
    endtask

    task automatic wait_until_drained();
        do @(posedge i_clk); while (pending_items.size() != 0 || s_axis_tvalid);
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_header(16'hFFFF, 32'd0, CHECK_WORD, 32'hFFFF_FFFF, HEADER_BYTES);
        queue_abort();
        queue_header(16'h0000, 32'd3, CHECK_WORD, 32'h0000_0000, HEADER_BYTES);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_abort();
        wait_until_drained();

        queue_header(16'($urandom), 32'd24, CHECK_WORD, $urandom, HEADER_BYTES);
        queue_payload(24);
        queue_header(16'($urandom), $urandom, ~CHECK_WORD, $urandom, HEADER_BYTES);
        stalls_requested++;
        queue_random_stream(260);
        wait_until_drained();

        queue_random_stream(400);
        wait_until_drained();

        idling_on = 1'b0;
        queue_random_stream(200);
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Drove %0d items (%0d aborts) with idling bursts and a %0d-cycle output stall.",
                 items_taken, aborts_seen, LONG_STALL_CYCLES);
        $display("Checked %0d results: %0d headers accepted, %0d rejected, %0d payload bytes.",
                 results_checked, headers_accepted, headers_rejected, payload_bytes);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("header_payload_deframer verification clean");
        end else begin
            $display("header_payload_deframer verification failed");
        end
        $finish;
    end

endmodule
